// ----- design/sfr_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfr_pkg: shared definitions for the stream find-and-replace block
// Constants, configuration register indexes and the structs that pass
// control between the top level and its window and output cells.
// ---------------------------------------------------------------------------
package sfr_pkg;

    localparam int unsigned MAX_PATTERN_DEF = 8;
    localparam int unsigned REPL_MAX        = 8;
    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned CFG_DATA_W      = 64;
    localparam int unsigned LEN_W           = 4;
    localparam int unsigned CFG_IDX_W       = 2;

    // One input transaction yields at most this many output bytes.
    localparam int unsigned RUN_MAX   = 8;
    localparam int unsigned RUN_CNT_W = $clog2(RUN_MAX + 1);

    // Output queue holds one leftover byte plus a full run.
    localparam int unsigned Q_DEPTH = RUN_MAX + 1;
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES  = 2'd0,
        CFG_PATTERN_LENGTH = 2'd1,
        CFG_REPL_BYTES     = 2'd2,
        CFG_REPL_LENGTH    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_res_item;

    typedef struct packed {
        logic shift_one;
        logic shift_far;
    } t_win_ctl;

    typedef struct packed {
        logic                 push;
        logic                 pop;
        logic                 base_one;
        logic [RUN_CNT_W-1:0] nres;
    } t_q_ctl;

endpackage

// ----- design/sfr_win_cell.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfr_win_cell: one byte of the pending window
// Holds a window byte, takes the incoming byte when it lands here, compares
// with its pattern byte and refills from a neighbor when the window moves.
// ---------------------------------------------------------------------------
module sfr_win_cell (
    input  logic                         i_clk,
    input  logic                         i_append,
    input  sfr_pkg::t_win_ctl            i_ctl,
    input  logic [sfr_pkg::BYTE_W-1:0]   i_new_byte,
    input  logic [sfr_pkg::BYTE_W-1:0]   i_next_byte,
    input  logic [sfr_pkg::BYTE_W-1:0]   i_far_byte,
    input  logic [sfr_pkg::BYTE_W-1:0]   i_pat_byte,
    output logic [sfr_pkg::BYTE_W-1:0]   o_cur,
    output logic                         o_match
);
    import sfr_pkg::*;

    logic [BYTE_W-1:0] r_byte;
    logic [BYTE_W-1:0] n_byte;

    // Value seen by the compare, after the incoming byte is placed.
    assign o_cur   = i_append ? i_new_byte : r_byte;
    assign o_match = (o_cur == i_pat_byte);

    always_comb begin
        priority if (i_ctl.shift_far) begin
            n_byte = i_far_byte;
        end else if (i_ctl.shift_one) begin
            n_byte = i_next_byte;
        end else begin
            n_byte = o_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

endmodule

// ----- design/sfr_out_cell.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfr_out_cell: one entry of the output queue
// Loads a result byte of a new run or moves up from the entry behind it
// as the head entry is delivered.
// ---------------------------------------------------------------------------
module sfr_out_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic               i_clk,
    input  sfr_pkg::t_q_ctl    i_ctl,
    input  sfr_pkg::t_res_item i_new_lo,
    input  sfr_pkg::t_res_item i_new_hi,
    input  sfr_pkg::t_res_item i_next,
    output sfr_pkg::t_res_item o_item
);
    import sfr_pkg::*;

    localparam int unsigned LO_IDX = (IDX > 0) ? IDX - 1 : 0;
    localparam bit          HAS_LO = (IDX > 0);

    t_res_item r_item;
    t_res_item n_item;
    logic      sel_hi;
    logic      sel_lo;

    // A run starts at entry 0, or at entry 1 when one byte is still waiting.
    assign sel_hi = i_ctl.push && !i_ctl.base_one
                    && (RUN_CNT_W'(IDX) < i_ctl.nres);
    assign sel_lo = HAS_LO && i_ctl.push && i_ctl.base_one
                    && (RUN_CNT_W'(LO_IDX) < i_ctl.nres);

    always_comb begin
        priority if (sel_hi) begin
            n_item = i_new_hi;
        end else if (sel_lo) begin
            n_item = i_new_lo;
        end else if (i_ctl.pop) begin
            n_item = i_next;
        end else begin
            n_item = r_item;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

    assign o_item = r_item;

endmodule

// ----- design/stream_find_and_replace.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stream_find_and_replace: streaming byte find-and-replace
// Replaces every leftmost, non-overlapping occurrence of a pattern in a
// byte stream with a replacement, using a row of window cells.
// ---------------------------------------------------------------------------
// Usage:
// The input channel (i_in_valid / o_in_stall) carries one text byte or an
// end-of-stream marker per transaction. The output channel (o_out_valid /
// i_out_stall) carries rewritten bytes; o_last_of_run marks the final byte
// caused by one input transaction. An input transaction causes zero to eight
// output bytes: none while the window fills, one when the oldest byte leaves,
// the replacement on a match, and the pending bytes on end of stream.
// Results are registered: an accepted transaction's bytes enter the output queue.
// The window compare and update are combinational, so a transaction that yields
// at most one byte does not hold up the next one unless the receiver stalls.
// Input is stalled while more than one byte waits in the output queue.
// The configuration port writes a register at each edge with i_cfg_we high;
// write it only while the block is idle.
// Reset empties the window and the output queue and sets the pattern length
// to one and the replacement length to zero. When the receiver stalls, the
// head byte holds and the queue fills until the input side stalls too.
// ---------------------------------------------------------------------------
module stream_find_and_replace #(
    parameter int unsigned MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [sfr_pkg::BYTE_W-1:0]       i_data_byte,
    input  logic                             i_end_of_stream,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [sfr_pkg::BYTE_W-1:0]       o_out_byte,
    output logic                             o_last_of_run
);
    import sfr_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_PATTERN + 1);

    // Configuration registers.
    logic [CFG_DATA_W-1:0] r_pat_bytes;
    logic [LEN_W-1:0]      r_pat_len;
    logic [CFG_DATA_W-1:0] r_repl_bytes;
    logic [LEN_W-1:0]      r_repl_len;

    logic [CNT_W-1:0]     plen;
    logic [RUN_CNT_W-1:0] rlen;

    // Window state.
    logic [CNT_W-1:0] r_win_cnt;
    logic [CNT_W-1:0] n_win_cnt;
    logic [CNT_W-1:0] cnt_app;

    logic [BYTE_W-1:0] win_cur  [MAX_PATTERN];
    logic [BYTE_W-1:0] win_next [MAX_PATTERN];
    logic [BYTE_W-1:0] win_far  [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] win_match;
    logic [MAX_PATTERN-1:0] win_mask;
    logic [MAX_PATTERN-1:0] win_append;
    t_win_ctl               win_ctl;

    logic in_acc;
    logic is_data;
    logic is_flush;
    logic has_room;
    logic full;
    logic hit;

    // Output queue.
    logic [Q_CNT_W-1:0]   r_q_cnt;
    logic [Q_CNT_W-1:0]   n_q_cnt;
    logic [RUN_CNT_W-1:0] nres;
    t_res_item            new_item [RUN_MAX];
    t_res_item            q_item   [Q_DEPTH];
    t_q_ctl               q_ctl;
    logic                 pop;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_bytes  <= '0;
            r_pat_len    <= LEN_W'(1);
            r_repl_bytes <= '0;
            r_repl_len   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PATTERN_BYTES:  r_pat_bytes  <= i_cfg_data;
                CFG_PATTERN_LENGTH: r_pat_len    <= i_cfg_data[LEN_W-1:0];
                CFG_REPL_BYTES:     r_repl_bytes <= i_cfg_data;
                CFG_REPL_LENGTH:    r_repl_len   <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // A zero pattern length acts as one; longer lengths saturate.
    always_comb begin
        priority if (r_pat_len == '0) begin
            plen = CNT_W'(1);
        end else if (r_pat_len > LEN_W'(MAX_PATTERN)) begin
            plen = CNT_W'(MAX_PATTERN);
        end else begin
            plen = CNT_W'(r_pat_len);
        end
        if (r_repl_len > LEN_W'(REPL_MAX)) begin
            rlen = RUN_CNT_W'(REPL_MAX);
        end else begin
            rlen = RUN_CNT_W'(r_repl_len);
        end
    end

    // ---------------- window ----------------
    assign o_in_stall = (r_q_cnt > Q_CNT_W'(1));
    assign in_acc     = i_in_valid && !o_in_stall;
    assign is_data    = in_acc && !i_end_of_stream;
    assign is_flush   = in_acc && i_end_of_stream;
    assign has_room   = (r_win_cnt < CNT_W'(MAX_PATTERN));
    assign cnt_app    = r_win_cnt + CNT_W'(is_data && has_room);
    assign full       = (cnt_app >= plen);
    assign hit        = is_data && full && (&(win_match | ~win_mask));

    assign win_ctl.shift_one = is_data && full && !hit;
    assign win_ctl.shift_far = hit;

    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            win_append[i] = is_data && has_room && (r_win_cnt == CNT_W'(i));
            win_mask[i]   = (CNT_W'(i) < plen);
            win_next[i]   = (i + 1 < MAX_PATTERN) ? win_cur[(i + 1) % MAX_PATTERN] : '0;
            // On a match the cell refills from the byte a full pattern behind it.
            win_far[i]    = '0;
            for (int k = 1; k <= MAX_PATTERN; k++) begin
                if (plen == CNT_W'(k) && i + k < MAX_PATTERN) begin
                    win_far[i] = win_cur[(i + k) % MAX_PATTERN];
                end
            end
        end
    end

    for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_win
        sfr_win_cell u_cell (
            .i_clk       (i_clk),
            .i_append    (win_append[g]),
            .i_ctl       (win_ctl),
            .i_new_byte  (i_data_byte),
            .i_next_byte (win_next[g]),
            .i_far_byte  (win_far[g]),
            .i_pat_byte  (r_pat_bytes[BYTE_W*g +: BYTE_W]),
            .o_cur       (win_cur[g]),
            .o_match     (win_match[g])
        );
    end

    always_comb begin
        n_win_cnt = r_win_cnt;
        if (is_flush) begin
            n_win_cnt = '0;
        end else if (hit) begin
            n_win_cnt = cnt_app - plen;
        end else if (is_data && full) begin
            n_win_cnt = cnt_app - CNT_W'(1);
        end else if (is_data) begin
            n_win_cnt = cnt_app;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_cnt <= '0;
        end else begin
            r_win_cnt <= n_win_cnt;
        end
    end

    // ---------------- result run ----------------
    always_comb begin
        priority if (is_flush) begin
            nres = RUN_CNT_W'(r_win_cnt);
        end else if (hit) begin
            nres = rlen;
        end else if (is_data && full) begin
            nres = RUN_CNT_W'(1);
        end else begin
            nres = '0;
        end
        for (int j = 0; j < RUN_MAX; j++) begin
            if (is_flush) begin
                new_item[j].data = (j < MAX_PATTERN) ? win_cur[j % MAX_PATTERN] : '0;
            end else if (hit) begin
                new_item[j].data = r_repl_bytes[BYTE_W*j +: BYTE_W];
            end else begin
                new_item[j].data = win_cur[0];
            end
            new_item[j].last = (RUN_CNT_W'(j + 1) == nres);
        end
    end

    // ---------------- output queue ----------------
    assign pop            = o_out_valid && !i_out_stall;
    assign q_ctl.push     = in_acc && (nres != '0);
    assign q_ctl.pop      = pop;
    assign q_ctl.base_one = (r_q_cnt == Q_CNT_W'(1)) && !pop;
    assign q_ctl.nres     = nres;

    for (genvar g = 0; g < Q_DEPTH; g++) begin : g_q
        t_res_item lo_item;
        t_res_item hi_item;
        t_res_item nx_item;

        assign lo_item = (g > 0) ? new_item[(g + RUN_MAX - 1) % RUN_MAX] : '0;
        assign hi_item = (g < RUN_MAX) ? new_item[g % RUN_MAX] : '0;
        assign nx_item = (g + 1 < Q_DEPTH) ? q_item[(g + 1) % Q_DEPTH] : '0;

        sfr_out_cell #(.IDX(g)) u_cell (
            .i_clk    (i_clk),
            .i_ctl    (q_ctl),
            .i_new_lo (lo_item),
            .i_new_hi (hi_item),
            .i_next   (nx_item),
            .o_item   (q_item[g])
        );
    end

    always_comb begin
        n_q_cnt = r_q_cnt - Q_CNT_W'(pop);
        if (q_ctl.push) begin
            n_q_cnt = n_q_cnt + Q_CNT_W'(nres);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_cnt <= '0;
        end else begin
            r_q_cnt <= n_q_cnt;
        end
    end

    assign o_out_valid   = (r_q_cnt != '0);
    assign o_out_byte    = q_item[0].data;
    assign o_last_of_run = q_item[0].last;

`ifndef SYNTHESIS
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_cnt <= Q_CNT_W'(Q_DEPTH))
        else $error("output queue overflow");

    a_win_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_win_cnt < CNT_W'(MAX_PATTERN))
        else $error("window holds too many bytes between transactions");

    a_flush_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_flush |=> (r_win_cnt == '0))
        else $error("end of stream did not empty the window");

    a_run_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last_of_run) |-> (r_q_cnt > Q_CNT_W'(1)))
        else $error("run head is not last but the rest of the run is missing");
`endif

endmodule
